>>> rtl/core/assert_macros.svh
// Assertion macros shared by the pink-noise pixel generator RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/pnpg_pkg.sv
// Package for the pink-noise pixel generator: payload types, sequencer states,
// default sizes, and the generator and palette helper functions. No dependencies.
package pnpg_pkg;

  localparam int ROWS_DEF         = 128;
  localparam int OCTAVE_COUNT_DEF = 16;
  localparam logic [31:0] SEED_RESET = 32'd1;

  localparam int OCTAVE_W = 16;
  localparam int GRAY_W   = 8;
  localparam int PAL_W    = 4;
  localparam int PAL_MAX  = 11;
  localparam int PAL_DIV  = 255;
  localparam int PAL_ROUND = 127;

  typedef struct packed {
    logic       action;
    logic [6:0] row;
    logic [9:0] column;
  } in_item_t;

  typedef struct packed {
    logic [GRAY_W-1:0] gray_level;
    logic [PAL_W-1:0]  palette_index;
  } out_item_t;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_INIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REFRESH,
    ST_INIT,
    ST_SCALE,
    ST_DIV,
    ST_FINISH
  } st_t;

  // One xorshift32 step.
  function automatic logic [31:0] xorshift32(logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // Rounded palette index: counts the multiples of 255 that gray*11+127 reaches.
  function automatic logic [PAL_W-1:0] palette_of(logic [GRAY_W-1:0] gray);
    logic [11:0]      scaled;
    logic [PAL_W-1:0] idx;
    scaled = 12'(gray) * 12'(PAL_MAX) + 12'(PAL_ROUND);
    idx = '0;
    for (int k = 1; k <= PAL_MAX; k++) begin
      if (scaled >= 12'(k * PAL_DIV)) idx = idx + PAL_W'(1);
    end
    return idx;
  endfunction

endpackage

>>> rtl/core/pink_noise_pixel_generator_core.sv
// Pink-noise pixel generator core: one octave memory holding each row's octaves, running row sums, a sequencer
// around one xorshift32 unit and a reciprocal scaler. Depends on pnpg_pkg, assert_macros.svh.
// Init item: ST_INIT draws every octave of the row, then IDLE takes the next item; no result.
// Pixel item: LOAD, REFRESH while octaves 0..top are refreshed, SCALE, DIV, then FINISH
// registers the result and returns to IDLE; a stalled result holds the sequencer in FINISH.
// Synchronous active-low reset clears sequencer, output valid and generator (seed 1) only.
`include "assert_macros.svh"

module pink_noise_pixel_generator_core #(
  parameter int ROWS         = pnpg_pkg::ROWS_DEF,
  parameter int OCTAVE_COUNT = pnpg_pkg::OCTAVE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pnpg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pnpg_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int K_W       = $clog2(OCTAVE_COUNT);
  localparam int OCT_DEPTH = ROWS * OCTAVE_COUNT;
  localparam int OA_W      = $clog2(OCT_DEPTH);
  localparam int SUM_W     = pnpg_pkg::OCTAVE_W + $clog2(OCTAVE_COUNT);
  localparam int N_W       = pnpg_pkg::GRAY_W + $clog2(OCTAVE_COUNT);
  localparam int DIV_SH    = N_W + K_W;
  localparam int RP_W      = N_W + DIV_SH;
  localparam logic [K_W-1:0] K_LAST = K_W'(OCTAVE_COUNT - 1);
  // Rounded-up reciprocal of OCTAVE_COUNT; exact for every scaled sum below 2^N_W.
  localparam logic [DIV_SH-1:0] RECIP =
    DIV_SH'(((1 << DIV_SH) + OCTAVE_COUNT - 1) / OCTAVE_COUNT);

  pnpg_pkg::st_t state_r, state_nxt;

  logic [ROW_W-1:0] row_r;
  logic [OA_W-1:0]  base_r;
  logic [K_W-1:0]   k_r;
  logic [31:0]      cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic [N_W-1:0]   rem_r;
  logic [7:0]       quo_r;
  logic [31:0]      gen_r;
  logic             refresh_r;
  logic             out_valid_r;
  pnpg_pkg::out_item_t out_data_r;

  logic [pnpg_pkg::OCTAVE_W-1:0] oct_mem [OCT_DEPTH];
  logic [31:0]                   cnt_mem [ROWS];
  logic [SUM_W-1:0]              sum_mem [ROWS];
  logic [pnpg_pkg::OCTAVE_W-1:0] oct_rd_r;
  logic [31:0]                   cnt_rd_r;
  logic [SUM_W-1:0]              sum_rd_r;

  logic             in_acc, row_ok, out_free, more;
  logic             init_acc, res_load;
  logic [ROW_W-1:0] in_row;
  logic [OA_W-1:0]  in_base;
  logic [31:0]      gen_nxt;
  logic [pnpg_pkg::OCTAVE_W-1:0] draw;
  logic [SUM_W+7:0] prod;
  logic [RP_W-1:0]  recip_prod;

  logic             oct_re, oct_we, row_re, cnt_we, sum_we;
  logic [OA_W-1:0]  oct_ra, oct_wa;
  logic [31:0]      cnt_wd;
  logic [SUM_W-1:0] sum_wd;

  assign in_acc   = in_valid && !in_stall;
  assign row_ok   = 32'(in_data.row) < 32'(ROWS);
  assign init_acc = in_acc && row_ok && (in_data.action == pnpg_pkg::ACT_INIT);
  assign in_row   = ROW_W'(in_data.row);
  assign in_base  = OA_W'(in_row * OCTAVE_COUNT);
  assign out_free = !out_valid_r || !out_stall;
  assign res_load = (state_r == pnpg_pkg::ST_FINISH) && out_free;
  // Octave k+1 is refreshed only when bits 0..k of the new counter are all zero.
  assign more     = (k_r != K_LAST) && !cnt_r[k_r];
  assign gen_nxt  = pnpg_pkg::xorshift32(gen_r);
  assign draw     = gen_nxt[31:16];
  // sum * 255, of which the bits above 2^16 are then divided by OCTAVE_COUNT.
  assign prod     = {sum_r, 8'b0} - {8'b0, sum_r};
  assign recip_prod = RP_W'(rem_r) * RP_W'(RECIP);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pnpg_pkg::ST_IDLE: begin
        if (in_acc && row_ok) begin
          state_nxt = (in_data.action == pnpg_pkg::ACT_INIT) ? pnpg_pkg::ST_INIT
                                                              : pnpg_pkg::ST_LOAD;
        end
      end
      pnpg_pkg::ST_LOAD:    state_nxt = refresh_r ? pnpg_pkg::ST_REFRESH : pnpg_pkg::ST_SCALE;
      pnpg_pkg::ST_REFRESH: state_nxt = more ? pnpg_pkg::ST_REFRESH : pnpg_pkg::ST_SCALE;
      pnpg_pkg::ST_INIT:    state_nxt = (k_r == K_LAST) ? pnpg_pkg::ST_IDLE : pnpg_pkg::ST_INIT;
      pnpg_pkg::ST_SCALE:   state_nxt = pnpg_pkg::ST_DIV;
      pnpg_pkg::ST_DIV:     state_nxt = pnpg_pkg::ST_FINISH;
      pnpg_pkg::ST_FINISH:  state_nxt = out_free ? pnpg_pkg::ST_IDLE : pnpg_pkg::ST_FINISH;
      default:              state_nxt = pnpg_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    oct_re    = 1'b0;
    oct_ra    = base_r + OA_W'(k_r) + OA_W'(1);
    oct_we    = 1'b0;
    oct_wa    = base_r + OA_W'(k_r);
    row_re    = 1'b0;
    cnt_we    = 1'b0;
    cnt_wd    = cnt_rd_r + 32'd1;
    sum_we    = 1'b0;
    sum_wd    = sum_r;
    unique case (state_r)
      pnpg_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        oct_ra    = in_base;
        row_re    = in_acc && row_ok && (in_data.action == pnpg_pkg::ACT_PIXEL);
        oct_re    = row_re && (in_data.column[1:0] == 2'b00);
      end
      pnpg_pkg::ST_LOAD: begin
        cnt_we = refresh_r;
      end
      pnpg_pkg::ST_REFRESH: begin
        oct_we = 1'b1;
        oct_re = more;
      end
      pnpg_pkg::ST_INIT: begin
        oct_we = 1'b1;
        cnt_we = (k_r == K_LAST);
        cnt_wd = '0;
        sum_we = (k_r == K_LAST);
        sum_wd = sum_r + SUM_W'(draw);
      end
      pnpg_pkg::ST_SCALE: begin
        sum_we = refresh_r;
      end
      pnpg_pkg::ST_DIV, pnpg_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (oct_we) oct_mem[oct_wa] <= draw;
    if (oct_re) oct_rd_r <= oct_mem[oct_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[row_r] <= cnt_wd;
    if (sum_we) sum_mem[row_r] <= sum_wd;
    if (row_re) begin
      cnt_rd_r <= cnt_mem[in_row];
      sum_rd_r <= sum_mem[in_row];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pnpg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= pnpg_pkg::SEED_RESET;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        gen_r <= (cfg_data == '0) ? pnpg_pkg::SEED_RESET : cfg_data;
      end else if (state_r == pnpg_pkg::ST_REFRESH || state_r == pnpg_pkg::ST_INIT) begin
        gen_r <= gen_nxt;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      pnpg_pkg::ST_IDLE: begin
        if (in_acc) begin
          row_r     <= in_row;
          base_r    <= in_base;
          refresh_r <= (in_data.column[1:0] == 2'b00);
          k_r       <= '0;
          sum_r     <= '0;
        end
      end
      pnpg_pkg::ST_LOAD: begin
        sum_r <= sum_rd_r;
        cnt_r <= cnt_rd_r + 32'd1;
      end
      pnpg_pkg::ST_REFRESH: begin
        sum_r <= sum_r + SUM_W'(draw) - SUM_W'(oct_rd_r);
        k_r   <= k_r + K_W'(1);
      end
      pnpg_pkg::ST_INIT: begin
        sum_r <= sum_r + SUM_W'(draw);
        k_r   <= k_r + K_W'(1);
      end
      pnpg_pkg::ST_SCALE: begin
        rem_r <= prod[SUM_W+7:16];
      end
      pnpg_pkg::ST_DIV: begin
        quo_r <= recip_prod[DIV_SH +: pnpg_pkg::GRAY_W];
      end
      pnpg_pkg::ST_FINISH: begin
        if (out_free) begin
          out_data_r.gray_level    <= quo_r;
          out_data_r.palette_index <= pnpg_pkg::palette_of(quo_r);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_SAME(a_gen_nonzero, 1'b1, gen_r != '0)
  `ASSERT_NEXT(a_init_entry, init_acc, state_r == pnpg_pkg::ST_INIT)
  `ASSERT_NEXT(a_result_loaded, res_load, out_valid_r && (state_r == pnpg_pkg::ST_IDLE))

endmodule
